// ===== rtl/lzd_pkg.sv =====
// Shared constants, types and helper functions of the LZ77 tuple decoder.
package lzd_pkg;

    localparam int WINDOW_BITS  = 12;
    localparam int MAX_LEN_BITS = 5;
    localparam int LIT_BITS     = 8;
    localparam int WINDOW_DEPTH = 1 << WINDOW_BITS;

    // Widest field a single take can return, and the width of a take count.
    localparam int FIELD_W = (WINDOW_BITS > LIT_BITS) ? WINDOW_BITS : LIT_BITS;
    localparam int TAKE_W  = $clog2(FIELD_W + 1);

    // Pending bits never exceed one tuple less a bit, plus one fresh byte.
    localparam int BUF_W = WINDOW_BITS + MAX_LEN_BITS + 2 * LIT_BITS - 1;
    localparam int CNT_W = $clog2(BUF_W + 1);

    // Configuration register file.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int DIST_CFG_W  = 4;
    localparam int LEN_CFG_W   = 3;

    localparam logic [CFG_INDEX_W-1:0] REG_DIST_BITS = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LEN_BITS  = 1'd1;

    localparam logic [DIST_CFG_W-1:0] DIST_BITS_RST = 4'd12;
    localparam logic [LEN_CFG_W-1:0]  LEN_BITS_RST  = 3'd4;

    // Command from the sequencer to the bit unpacker.
    typedef struct packed {
        logic              append;
        logic              take;
        logic              clear;
        logic [7:0]        code_in;
        logic [TAKE_W-1:0] take_n;
    } lzd_unpack_op_t;

    function automatic logic [7:0] reverse_byte(input logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = b[7-i];
        end
        return r;
    endfunction

    function automatic logic [TAKE_W-1:0] clamp_dist(input logic [DIST_CFG_W-1:0] v);
        logic [TAKE_W-1:0] r;
        if (v == '0) begin
            r = TAKE_W'(1);
        end else if (int'(v) > WINDOW_BITS) begin
            r = TAKE_W'(WINDOW_BITS);
        end else begin
            r = TAKE_W'(v);
        end
        return r;
    endfunction

    function automatic logic [TAKE_W-1:0] clamp_len(input logic [LEN_CFG_W-1:0] v);
        logic [TAKE_W-1:0] r;
        if (v == '0) begin
            r = TAKE_W'(1);
        end else if (int'(v) > MAX_LEN_BITS) begin
            r = TAKE_W'(MAX_LEN_BITS);
        end else begin
            r = TAKE_W'(v);
        end
        return r;
    endfunction

endpackage

// ===== rtl/lz77_tuple_decoder.sv =====
// Top level of the LZ77 tuple decoder: sequencer, window memory and output register.
//
// Takes one compressed byte per input beat, bits most significant first, and
// decodes tuples of {distance (dist_bits), length (len_bits), 8-bit literal},
// each field least significant bit first. A tuple with nonzero distance emits
// length bytes copied one at a time from distance back in a 4096-byte window
// (overlapping runs repeat), then the literal with m_tlast high; a zero
// distance emits the literal alone. s_tlast drops the bits left over once any
// tuple that byte completes has been decoded. Widths are saturated to their
// legal range at decode time. Steps: a byte that completes no tuple passes the
// idle and check states; one that completes a tuple then takes the distance,
// length and literal in turn, one field per cycle, then per copied byte a window
// read and a window write, then the literal, each output step held by any stall.
// The window needs no clearing pass after reset: a wrap flag and the write
// pointer tell which entries were written, and unwritten ones read as zero.
// s_tready is low while a byte is being worked; cfg_ready is always high and
// writes are meant for idle periods only.
module lz77_tuple_decoder (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // [7:0] code_byte
    input  logic                               s_tlast,   // last
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [7:0]                         m_tdata,   // [7:0] out_byte
    output logic                               m_tlast,   // tuple_end
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [lzd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lzd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lzd_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_TDIST = 8'b0000_0100,
        S_TLEN  = 8'b0000_1000,
        S_TLIT  = 8'b0001_0000,
        S_READ  = 8'b0010_0000,
        S_COPY  = 8'b0100_0000,
        S_LIT   = 8'b1000_0000
    } lzd_state_t;

    lzd_state_t                state_reg, state_next;

    logic [DIST_CFG_W-1:0]     dist_bits_reg, dist_bits_next;
    logic [LEN_CFG_W-1:0]      len_bits_reg, len_bits_next;

    logic [TAKE_W-1:0]         dw_reg, dw_next;
    logic [TAKE_W-1:0]         lw_reg, lw_next;
    logic                      last_reg, last_next;
    logic [WINDOW_BITS-1:0]    dist_reg, dist_next;
    logic [MAX_LEN_BITS-1:0]   run_reg, run_next;
    logic [7:0]                lit_reg, lit_next;
    logic [WINDOW_BITS-1:0]    src_reg, src_next;
    logic [WINDOW_BITS-1:0]    wpos_reg, wpos_next;
    logic                      wrapped_reg, wrapped_next;
    logic                      rd_ok_reg, rd_ok_next;

    logic                      m_valid_reg, m_valid_next;
    logic [7:0]                m_byte_reg, m_byte_next;
    logic                      m_end_reg, m_end_next;

    lzd_unpack_op_t            uop;
    logic [FIELD_W-1:0]        field;
    logic [CNT_W-1:0]          bit_cnt;
    logic [TAKE_W-1:0]         dw_cur, lw_cur;
    logic [CNT_W-1:0]          need;

    logic                      out_free;
    logic                      ram_we, ram_re;
    logic [7:0]                ram_wdata, ram_rdata;

    lzd_bit_unpack u_unpack (
        .aclk    (aclk),
        .aresetn (aresetn),
        .op      (uop),
        .field   (field),
        .bit_cnt (bit_cnt)
    );

    lzd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (wpos_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (src_reg),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    // Widths in force for the next tuple, saturated to their legal range.
    assign dw_cur = clamp_dist(dist_bits_reg);
    assign lw_cur = clamp_len(len_bits_reg);
    assign need   = CNT_W'(dw_cur) + CNT_W'(lw_cur) + CNT_W'(LIT_BITS);

    // Configuration registers.
    always_comb begin
        dist_bits_next = dist_bits_reg;
        len_bits_next  = len_bits_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DIST_BITS: dist_bits_next = cfg_data[DIST_CFG_W-1:0];
                REG_LEN_BITS:  len_bits_next  = cfg_data[LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        state_next   = state_reg;
        dw_next      = dw_reg;
        lw_next      = lw_reg;
        last_next    = last_reg;
        dist_next    = dist_reg;
        run_next     = run_reg;
        lit_next     = lit_reg;
        src_next     = src_reg;
        wpos_next    = wpos_reg;
        wrapped_next = wrapped_reg;
        rd_ok_next   = rd_ok_reg;
        m_byte_next  = m_byte_reg;
        m_end_next   = m_end_reg;
        m_valid_next = m_valid_reg && !m_tready;

        uop          = '0;
        uop.code_in  = s_tdata;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_wdata    = lit_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    uop.append = 1'b1;
                    last_next  = s_tlast;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (bit_cnt >= need) begin
                    dw_next    = dw_cur;
                    lw_next    = lw_cur;
                    state_next = S_TDIST;
                end else begin
                    // no full tuple: drop leftovers on the final byte
                    uop.clear  = last_reg;
                    state_next = S_IDLE;
                end
            end
            S_TDIST: begin
                uop.take   = 1'b1;
                uop.take_n = dw_reg;
                dist_next  = field[WINDOW_BITS-1:0];
                state_next = S_TLEN;
            end
            S_TLEN: begin
                uop.take   = 1'b1;
                uop.take_n = lw_reg;
                run_next   = field[MAX_LEN_BITS-1:0];
                state_next = S_TLIT;
            end
            S_TLIT: begin
                uop.take   = 1'b1;
                uop.take_n = TAKE_W'(LIT_BITS);
                lit_next   = field[7:0];
                src_next   = wpos_reg - dist_reg;
                if (dist_reg != '0 && run_reg != '0) begin
                    state_next = S_READ;
                end else begin
                    state_next = S_LIT;
                end
            end
            S_READ: begin
                // entries not yet written since reset read as zero
                ram_re     = 1'b1;
                rd_ok_next = wrapped_reg || (src_reg < wpos_reg);
                src_next   = src_reg + WINDOW_BITS'(1);
                state_next = S_COPY;
            end
            S_COPY: begin
                ram_wdata = rd_ok_reg ? ram_rdata : 8'd0;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = ram_wdata;
                    m_end_next   = 1'b0;
                    ram_we       = 1'b1;
                    wpos_next    = wpos_reg + WINDOW_BITS'(1);
                    wrapped_next = wrapped_reg || (wpos_reg == '1);
                    run_next     = run_reg - MAX_LEN_BITS'(1);
                    state_next   = (run_reg == MAX_LEN_BITS'(1)) ? S_LIT : S_READ;
                end
            end
            S_LIT: begin
                ram_wdata = lit_reg;
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = lit_reg;
                    m_end_next   = 1'b1;
                    ram_we       = 1'b1;
                    wpos_next    = wpos_reg + WINDOW_BITS'(1);
                    wrapped_next = wrapped_reg || (wpos_reg == '1);
                    uop.clear    = last_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            dist_bits_reg <= DIST_BITS_RST;
            len_bits_reg  <= LEN_BITS_RST;
            wpos_reg      <= '0;
            wrapped_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
            last_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            dist_bits_reg <= dist_bits_next;
            len_bits_reg  <= len_bits_next;
            wpos_reg      <= wpos_next;
            wrapped_reg   <= wrapped_next;
            m_valid_reg   <= m_valid_next;
            last_reg      <= last_next;
        end
    end

    // Payload registers hold without reset.
    always_ff @(posedge aclk) begin
        dw_reg     <= dw_next;
        lw_reg     <= lw_next;
        dist_reg   <= dist_next;
        run_reg    <= run_next;
        lit_reg    <= lit_next;
        src_reg    <= src_next;
        rd_ok_reg  <= rd_ok_next;
        m_byte_reg <= m_byte_next;
        m_end_reg  <= m_end_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tlast  = m_end_reg;

    // The accumulator always has room for a fresh byte when one is accepted.
    a_room_for_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> (bit_cnt <= CNT_W'(BUF_W - LIT_BITS)))
        else $error("bit accumulator overflow on accepted byte");

    // Field takes start only with a whole tuple pending.
    a_tuple_complete: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TDIST)
            |-> (bit_cnt >= CNT_W'(dw_reg) + CNT_W'(lw_reg) + CNT_W'(LIT_BITS)))
        else $error("tuple decode started without enough bits");

    // A copy run never runs with an exhausted byte count.
    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ || state_reg == S_COPY) |-> (run_reg != '0))
        else $error("copy state with zero remaining length");

endmodule

// ===== rtl/lzd_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lzd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lzd_bit_unpack.sv =====
// Bit accumulator: appends bit-reversed bytes and takes fields through one shifter.
module lzd_bit_unpack (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lzd_pkg::lzd_unpack_op_t       op,
    output logic [lzd_pkg::FIELD_W-1:0]   field,
    output logic [lzd_pkg::CNT_W-1:0]     bit_cnt
);
    import lzd_pkg::*;

    logic [BUF_W-1:0]   buf_reg, buf_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [FIELD_W:0]   mask_wide;

    // Low n bits of the accumulator; n may equal FIELD_W.
    assign mask_wide = ((FIELD_W+1)'(1) << op.take_n) - (FIELD_W+1)'(1);
    assign field     = buf_reg[FIELD_W-1:0] & mask_wide[FIELD_W-1:0];

    always_comb begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (op.clear) begin
            buf_next = '0;
            cnt_next = '0;
        end else if (op.append) begin
            buf_next = buf_reg | (BUF_W'(reverse_byte(op.code_in)) << cnt_reg);
            cnt_next = cnt_reg + CNT_W'(LIT_BITS);
        end else if (op.take) begin
            buf_next = buf_reg >> op.take_n;
            cnt_next = cnt_reg - CNT_W'(op.take_n);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg <= '0;
            cnt_reg <= '0;
        end else begin
            buf_reg <= buf_next;
            cnt_reg <= cnt_next;
        end
    end

    assign bit_cnt = cnt_reg;

endmodule
